// ===== sv/set_assoc_writeback_cache_tags_unit_defines.svh =====
// Assertion helpers for the cache tag unit.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef SET_ASSOC_WRITEBACK_CACHE_TAGS_UNIT_DEFINES_SVH
`define SET_ASSOC_WRITEBACK_CACHE_TAGS_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SACWT_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SACWT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sacwt_pkg.sv =====
package sacwt_pkg;

  // Default geometry
  localparam int unsigned SETS_DEFAULT    = 64;
  localparam int unsigned WAYS_DEFAULT    = 4;
  localparam int unsigned AGE_MOD_DEFAULT = 128;

  // Field widths
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned TAG_W      = 32;
  localparam int unsigned OFFSET_W   = 5;
  localparam int unsigned INDEX_W    = 3;
  localparam int unsigned SETIDX_W   = 6;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned CFG_IDX_W  = 1;

  // Configuration limits and reset values
  localparam logic [OFFSET_W-1:0] OFFSET_MAX   = 5'd16;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 5'd6;
  localparam logic [INDEX_W-1:0]  INDEX_MAX    = 3'd6;
  localparam logic [INDEX_W-1:0]  INDEX_RESET  = 3'd6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 1'b1;

  // Access opcodes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

endpackage

// ===== sv/sacwt_row_ram.sv =====
module sacwt_row_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write one row
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read one row, hold data until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// ===== sv/set_assoc_writeback_cache_tags_unit.sv =====
// Tag, valid, dirty and age store of a set-associative write-back cache.
// Input channel: opcode_i (0 read, 1 write) and byte address_i, transferred
// when in_valid_i is high and in_stall_o is low. Output channel: one result
// per access (hit_o, fill_needed_o, writeback_o, victim_address_o), taken
// when out_valid_o is high and out_stall_i is low.
// Each access reads its set row from the row memory, then one shared tag
// compare and age compare steps over the ways, one way per cycle, then the
// updated row is written back. A new access is taken only once the last one
// has written its row back.
// The output register parts the channels: the next access is taken while a
// result waits; if the receiver still stalls when the next result is ready,
// the unit holds that access in its final step until the output frees up.
// After reset a clearing pass zeroes every row (valid, dirty, ages);
// in_stall_o stays high meanwhile. Configuration writes through cfg_we_i
// are taken at any time and apply to each access whose address is split after them.
`include "set_assoc_writeback_cache_tags_unit_defines.svh"

module set_assoc_writeback_cache_tags_unit #(
  parameter int unsigned SETS    = sacwt_pkg::SETS_DEFAULT,
  parameter int unsigned WAYS    = sacwt_pkg::WAYS_DEFAULT,
  parameter int unsigned AGE_MOD = sacwt_pkg::AGE_MOD_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sacwt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sacwt_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              opcode_i,
  input  logic [sacwt_pkg::ADDR_W-1:0]      address_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              hit_o,
  output logic                              fill_needed_o,
  output logic                              writeback_o,
  output logic [sacwt_pkg::ADDR_W-1:0]      victim_address_o
);

  localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned AGE_W = $clog2(AGE_MOD);
  localparam int unsigned TAG_W = sacwt_pkg::TAG_W;

  typedef struct packed {
    logic [WAYS-1:0]            valid;
    logic [WAYS-1:0]            dirty;
    logic [WAYS-1:0][AGE_W-1:0] age;
    logic [WAYS-1:0][TAG_W-1:0] tag;
  } row_t;

  localparam int unsigned ROW_BITS = $bits(row_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPLIT,
    ST_SCAN,
    ST_WRITE
  } state_e;

  // Fold a set index into the row range: index modulo SETS
  function automatic logic [sacwt_pkg::SETIDX_W-1:0] set_fold(
    logic [sacwt_pkg::SETIDX_W-1:0] idx
  );
    logic [sacwt_pkg::SETIDX_W-1:0] r;
    r = idx;
    for (int k = sacwt_pkg::SETIDX_W - 1; k >= 0; k--) begin
      if (32'(r) >= (32'(SETS) << k)) begin
        r = r - sacwt_pkg::SETIDX_W'(32'(SETS) << k);
      end
    end
    return r;
  endfunction

  // Age one step modulo AGE_MOD
  function automatic logic [AGE_W-1:0] age_inc(logic [AGE_W-1:0] a);
    logic [AGE_W-1:0] n;
    n = (a == AGE_W'(AGE_MOD - 1)) ? '0 : a + AGE_W'(1);
    return n;
  endfunction

  state_e state_q;

  logic [sacwt_pkg::OFFSET_W-1:0] offset_bits_q;
  logic [sacwt_pkg::INDEX_W-1:0]  index_bits_q;

  logic                           op_q;
  logic [sacwt_pkg::ADDR_W-1:0]   addr_q;
  logic [sacwt_pkg::SETIDX_W-1:0] setidx_q;
  logic [TAG_W-1:0]               tag_q;
  logic [sacwt_pkg::OFFSET_W-1:0] off_q;
  logic [sacwt_pkg::OFFSET_W-1:0] sh_q;
  logic [SET_W-1:0]               row_q;
  logic [SET_W-1:0]               clr_q;
  logic [WAY_W-1:0]               way_q;
  logic                           hit_q;
  logic [WAY_W-1:0]               hit_way_q;
  logic [WAY_W-1:0]               vict_q;
  logic [AGE_W-1:0]               best_q;

  logic                           out_valid_q;
  logic                           hit_out_q;
  logic                           fill_out_q;
  logic                           wb_out_q;
  logic [sacwt_pkg::ADDR_W-1:0]   vaddr_out_q;

  // Address split
  logic [sacwt_pkg::OFFSET_W-1:0] off_c;
  logic [sacwt_pkg::INDEX_W-1:0]  ib_c;
  logic [sacwt_pkg::OFFSET_W-1:0] sh_c;
  logic [sacwt_pkg::SETIDX_W-1:0] mask_c;
  logic [sacwt_pkg::ADDR_W-1:0]   shifted_c;
  logic [sacwt_pkg::SETIDX_W-1:0] setidx_c;
  logic [TAG_W-1:0]               tag_c;
  logic [SET_W-1:0]               row_c;

  always_comb begin
    off_c     = (offset_bits_q > sacwt_pkg::OFFSET_MAX) ? sacwt_pkg::OFFSET_MAX
                                                        : offset_bits_q;
    ib_c      = (index_bits_q > sacwt_pkg::INDEX_MAX) ? sacwt_pkg::INDEX_MAX
                                                      : index_bits_q;
    sh_c      = off_c + sacwt_pkg::OFFSET_W'(ib_c);
    mask_c    = sacwt_pkg::SETIDX_W'((7'd1 << ib_c) - 7'd1);
    shifted_c = addr_q >> off_c;
    setidx_c  = shifted_c[sacwt_pkg::SETIDX_W-1:0] & mask_c;
    tag_c     = addr_q >> sh_c;
    row_c     = SET_W'(set_fold(setidx_c));
  end

  // Row memory
  logic                ram_wr_en;
  logic [SET_W-1:0]    ram_wr_addr;
  logic [ROW_BITS-1:0] ram_wr_data;
  logic                ram_rd_en;
  logic [ROW_BITS-1:0] ram_rd_data;
  row_t                rd_row;
  row_t                row_d;
  logic                out_block;

  assign rd_row    = row_t'(ram_rd_data);
  assign out_block = out_valid_q && out_stall_i;
  assign ram_rd_en = (state_q == ST_SPLIT);

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = row_q;
    ram_wr_data = ROW_BITS'(row_d);
    if (state_q == ST_CLEAR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_q;
      ram_wr_data = '0;
    end else if (state_q == ST_WRITE && !out_block) begin
      ram_wr_en = 1'b1;
    end
  end

  sacwt_row_ram #(
    .DATA_W (ROW_BITS),
    .DEPTH  (SETS),
    .ADDR_W (SET_W)
  ) u_row_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (row_c),
    .rd_data_o (ram_rd_data)
  );

  // Current way for the shared compare
  logic             cur_valid;
  logic [AGE_W-1:0] cur_age;
  logic [TAG_W-1:0] cur_tag;
  logic             cur_match;
  logic             cur_older;

  assign cur_valid = rd_row.valid[way_q];
  assign cur_age   = rd_row.age[way_q];
  assign cur_tag   = rd_row.tag[way_q];
  assign cur_match = cur_valid && (cur_tag == tag_q);
  assign cur_older = (way_q == '0) || (cur_age > best_q);

  // Build the updated row
  always_comb begin
    row_d = rd_row;
    for (int w = 0; w < int'(WAYS); w++) begin
      if (hit_q) begin
        if (WAY_W'(w) == hit_way_q) begin
          row_d.age[w]   = '0;
          row_d.dirty[w] = rd_row.dirty[w] | (op_q == sacwt_pkg::OP_WRITE);
        end else if (rd_row.valid[w]) begin
          row_d.age[w] = age_inc(rd_row.age[w]);
        end
      end else if (WAY_W'(w) == vict_q) begin
        row_d.valid[w] = 1'b1;
        row_d.dirty[w] = (op_q == sacwt_pkg::OP_WRITE);
        row_d.age[w]   = '0;
        row_d.tag[w]   = tag_q;
      end
    end
  end

  // Victim fields
  logic                         vict_valid;
  logic                         vict_dirty;
  logic [sacwt_pkg::ADDR_W-1:0] vaddr_c;

  assign vict_valid = rd_row.valid[vict_q];
  assign vict_dirty = rd_row.dirty[vict_q];
  assign vaddr_c    = (rd_row.tag[vict_q] << sh_q)
                    | (sacwt_pkg::ADDR_W'(setidx_q) << off_q);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_bits_q <= sacwt_pkg::OFFSET_RESET;
      index_bits_q  <= sacwt_pkg::INDEX_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sacwt_pkg::CFG_OFFSET_BITS: offset_bits_q <= cfg_data_i;
        sacwt_pkg::CFG_INDEX_BITS:  index_bits_q  <= cfg_data_i[sacwt_pkg::INDEX_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      op_q        <= 1'b0;
      addr_q      <= '0;
      setidx_q    <= '0;
      tag_q       <= '0;
      off_q       <= '0;
      sh_q        <= '0;
      row_q       <= '0;
      way_q       <= '0;
      hit_q       <= 1'b0;
      hit_way_q   <= '0;
      vict_q      <= '0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
      hit_out_q   <= 1'b0;
      fill_out_q  <= 1'b0;
      wb_out_q    <= 1'b0;
      vaddr_out_q <= '0;
    end else begin
      // Drop the result once transferred, unless the final step reloads it
      if (out_valid_q && !out_stall_i && state_q != ST_WRITE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + SET_W'(1);
          if (clr_q == SET_W'(SETS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            op_q    <= opcode_i;
            addr_q  <= address_i;
            state_q <= ST_SPLIT;
          end
        end
        ST_SPLIT: begin
          setidx_q <= setidx_c;
          tag_q    <= tag_c;
          off_q    <= off_c;
          sh_q     <= sh_c;
          row_q    <= row_c;
          way_q    <= '0;
          hit_q    <= 1'b0;
          state_q  <= ST_SCAN;
        end
        ST_SCAN: begin
          if (!hit_q && cur_match) begin
            hit_q     <= 1'b1;
            hit_way_q <= way_q;
          end
          if (cur_older) begin
            best_q <= cur_age;
            vict_q <= way_q;
          end
          if (way_q == WAY_W'(WAYS - 1)) begin
            state_q <= ST_WRITE;
          end else begin
            way_q <= way_q + WAY_W'(1);
          end
        end
        ST_WRITE: begin
          if (!out_block) begin
            out_valid_q <= 1'b1;
            hit_out_q   <= hit_q;
            fill_out_q  <= !hit_q;
            wb_out_q    <= !hit_q && vict_valid && vict_dirty;
            vaddr_out_q <= (!hit_q && vict_valid) ? vaddr_c : '0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign hit_o            = hit_out_q;
  assign fill_needed_o    = fill_out_q;
  assign writeback_o      = wb_out_q;
  assign victim_address_o = vaddr_out_q;

  // Checks
  `SACWT_ASSERT(a_hit_xor_fill, out_valid_o, hit_o != fill_needed_o, "hit and fill_needed agree")
  `SACWT_ASSERT(a_wb_only_on_miss, out_valid_o && writeback_o, fill_needed_o && !hit_o, "writeback on a hit")
  `SACWT_ASSERT(a_hit_no_victim, out_valid_o && hit_o, victim_address_o == '0 && !writeback_o, "victim on a hit")
  `SACWT_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "ready right after a transfer")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned SETS       = sacwt_pkg::SETS_DEFAULT;
  localparam int unsigned WAYS       = sacwt_pkg::WAYS_DEFAULT;
  localparam int unsigned AGE_MOD    = sacwt_pkg::AGE_MOD_DEFAULT;
  localparam int unsigned AGE_W      = $clog2(AGE_MOD);
  localparam int unsigned LINES      = SETS * WAYS;
  localparam int unsigned ADDR_W     = sacwt_pkg::ADDR_W;
  localparam int unsigned IDLE_PCT   = 38;
  localparam int unsigned QUIET_LIMIT = 4000;

  typedef struct packed {
    logic              hit;
    logic              fill_needed;
    logic              writeback;
    logic [ADDR_W-1:0] victim_address;
  } access_result_t;

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 cfg_we_i;
  logic [sacwt_pkg::CFG_IDX_W-1:0]      cfg_index_i;
  logic [sacwt_pkg::CFG_DATA_W-1:0]     cfg_data_i;
  logic                                 in_valid_i;
  logic                                 in_stall_o;
  logic                                 opcode_i;
  logic [ADDR_W-1:0]                    address_i;
  logic                                 out_valid_o;
  logic                                 out_stall_i;
  logic                                 hit_o;
  logic                                 fill_needed_o;
  logic                                 writeback_o;
  logic [ADDR_W-1:0]                    victim_address_o;

  // Shadow copy of the tag store and its split registers
  logic [sacwt_pkg::OFFSET_W-1:0] shadow_offset_bits;
  logic [sacwt_pkg::INDEX_W-1:0]  shadow_index_bits;
  logic                           line_valid [LINES];
  logic                           line_dirty [LINES];
  logic [AGE_W-1:0]               line_age   [LINES];
  logic [ADDR_W-1:0]              line_tag   [LINES];

  access_result_t pending_results[$];
  bit             idle_en = 1'b1;
  int unsigned    errors;
  int unsigned    n_accesses;
  int unsigned    n_hits;
  int unsigned    n_misses;
  int unsigned    n_writebacks;
  int unsigned    n_settings;

  set_assoc_writeback_cache_tags_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .address_i        (address_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .hit_o            (hit_o),
    .fill_needed_o    (fill_needed_o),
    .writeback_o      (writeback_o),
    .victim_address_o (victim_address_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Shadow store starts out in its post-reset state
  initial begin
    shadow_offset_bits = sacwt_pkg::OFFSET_RESET;
    shadow_index_bits  = sacwt_pkg::INDEX_RESET;
    for (int i = 0; i < LINES; i++) begin
      line_valid[i] = 1'b0;
      line_dirty[i] = 1'b0;
      line_age[i]   = '0;
      line_tag[i]   = '0;
    end
  end

  // Clamp the split registers the way the unit does
  function automatic int unsigned split_offset();
    return (shadow_offset_bits > sacwt_pkg::OFFSET_MAX) ? sacwt_pkg::OFFSET_MAX
                                                         : shadow_offset_bits;
  endfunction

  function automatic int unsigned split_index();
    return (shadow_index_bits > sacwt_pkg::INDEX_MAX) ? sacwt_pkg::INDEX_MAX
                                                       : shadow_index_bits;
  endfunction

  // Look up one access in the shadow store, update it, return the outcome
  function automatic access_result_t cache_lookup(logic op, logic [ADDR_W-1:0] addr);
    access_result_t res;
    int unsigned    off;
    int unsigned    ib;
    int unsigned    base;
    int unsigned    victim;
    int             hit_way;
    int             w;
    logic [ADDR_W-1:0] set_sel;
    logic [ADDR_W-1:0] tag;
    logic [63:0]       blk;
    off     = split_offset();
    ib      = split_index();
    set_sel = (addr >> off) & ((32'd1 << ib) - 32'd1);
    tag     = addr >> (off + ib);
    base    = (set_sel % SETS) * WAYS;
    res     = '0;
    hit_way = -1;
    for (w = 0; w < WAYS; w++) begin
      if (hit_way < 0 && line_valid[base+w] && line_tag[base+w] == tag) hit_way = w;
    end
    if (hit_way >= 0) begin
      // Age every other valid way, make the hit way youngest
      for (w = 0; w < WAYS; w++) begin
        if (w != hit_way && line_valid[base+w]) begin
          line_age[base+w] = AGE_W'((int'(line_age[base+w]) + 1) % AGE_MOD);
        end
      end
      line_age[base+hit_way] = '0;
      if (op == sacwt_pkg::OP_WRITE) line_dirty[base+hit_way] = 1'b1;
      res.hit = 1'b1;
    end else begin
      // Oldest way goes, ties to the lowest way
      victim = 0;
      for (w = 1; w < WAYS; w++) begin
        if (line_age[base+w] > line_age[base+victim]) victim = w;
      end
      res.fill_needed = 1'b1;
      res.writeback   = line_valid[base+victim] && line_dirty[base+victim];
      if (line_valid[base+victim]) begin
        blk = (64'(line_tag[base+victim]) << (off + ib)) | (64'(set_sel) << off);
        res.victim_address = blk[ADDR_W-1:0];
      end
      line_valid[base+victim] = 1'b1;
      line_dirty[base+victim] = (op == sacwt_pkg::OP_WRITE);
      line_age[base+victim]   = '0;
      line_tag[base+victim]   = tag;
    end
    return res;
  endfunction

  // Build an address from tag, set and byte fields under the current split
  function automatic logic [ADDR_W-1:0] compose_address(logic [ADDR_W-1:0] tag,
                                                         logic [ADDR_W-1:0] set_sel,
                                                         logic [ADDR_W-1:0] byte_sel);
    int unsigned off;
    int unsigned ib;
    off = split_offset();
    ib  = split_index();
    return (tag << (off + ib)) | ((set_sel & ((32'd1 << ib) - 32'd1)) << off)
         | (byte_sel & ((32'd1 << off) - 32'd1));
  endfunction

  // Drive one access, hold it until the transfer, then record the expectation
  task automatic send_access(logic op, logic [ADDR_W-1:0] addr);
    access_result_t res;
    int unsigned    gap;
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i = 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    opcode_i   = op;
    address_i  = addr;
    do @(posedge clk_i); while (in_stall_o);
    res = cache_lookup(op, addr);
    pending_results.insert(pending_results.size(), res);
    n_accesses++;
    if (res.hit) n_hits++;
    else n_misses++;
    if (res.writeback) n_writebacks++;
  endtask

  // Drop valid and hold until every outstanding result has come back
  task automatic wait_results_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Write both split registers once the unit is idle
  task automatic set_split(logic [sacwt_pkg::CFG_DATA_W-1:0] off_data,
                           logic [sacwt_pkg::CFG_DATA_W-1:0] idx_data);
    wait_results_drained();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = sacwt_pkg::CFG_OFFSET_BITS;
    cfg_data_i  = off_data;
    @(posedge clk_i);
    shadow_offset_bits = off_data;
    @(negedge clk_i);
    cfg_index_i = sacwt_pkg::CFG_INDEX_BITS;
    cfg_data_i  = idx_data;
    @(posedge clk_i);
    shadow_index_bits = idx_data[sacwt_pkg::INDEX_W-1:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    n_settings++;
  endtask

  // Hits, write hits, misses into empty, clean and dirty ways, address extremes
  task automatic test_directed_accesses();
    logic [ADDR_W-1:0] addrs[14] = '{32'h0000_0000, 32'h0000_003F, 32'h0000_1000,
                                     32'h0000_2000, 32'hFFFF_FFFF, 32'hFFFF_FFC0,
                                     32'h0000_0FC0, 32'h0000_0FC0, 32'hFFFF_F000,
                                     32'h8000_0040, 32'h8000_0040, 32'h0000_0040,
                                     32'hAAAA_AAAA, 32'h5555_5555};
    logic ops[14] = '{sacwt_pkg::OP_READ,  sacwt_pkg::OP_WRITE, sacwt_pkg::OP_READ,
                      sacwt_pkg::OP_READ,  sacwt_pkg::OP_WRITE, sacwt_pkg::OP_READ,
                      sacwt_pkg::OP_WRITE, sacwt_pkg::OP_WRITE, sacwt_pkg::OP_READ,
                      sacwt_pkg::OP_WRITE, sacwt_pkg::OP_WRITE, sacwt_pkg::OP_READ,
                      sacwt_pkg::OP_WRITE, sacwt_pkg::OP_READ};
    for (int i = 0; i < 14; i++) send_access(ops[i], addrs[i]);
  endtask

  // Extreme and out-of-range splits, reusing tags stored under the old split
  task automatic test_split_extremes();
    logic [sacwt_pkg::CFG_DATA_W-1:0] offs[4] = '{5'd0, 5'd16, 5'd31, 5'd24};
    logic [sacwt_pkg::CFG_DATA_W-1:0] idxs[4] = '{5'd0, 5'd6, 5'd7, 5'b11011};
    for (int i = 0; i < 4; i++) begin
      set_split(offs[i], idxs[i]);
      send_access(sacwt_pkg::OP_READ, 32'h0000_0000);
      send_access(sacwt_pkg::OP_WRITE, 32'hFFFF_FFFF);
      send_access(sacwt_pkg::OP_READ, 32'hFFFF_FFFF);
    end
  endtask

  // Phases of local and scattered traffic under a range of splits
  task automatic test_random_traffic();
    int unsigned phase_off[9] = '{6, 0, 16, 31, 3, 12, 0, 16, 0};
    int unsigned phase_idx[9] = '{6, 0, 6, 7, 1, 4, 6, 0, 0};
    int unsigned phase_len[9] = '{80, 80, 80, 70, 70, 70, 70, 60, 60};
    logic [sacwt_pkg::CFG_DATA_W-1:0] idx_data;
    logic [ADDR_W-1:0] tag;
    logic [ADDR_W-1:0] addr;
    logic              op;
    for (int p = 0; p < 9; p++) begin
      if (p == 8) begin
        phase_off[p] = $urandom_range(0, 31);
        phase_idx[p] = $urandom_range(0, 7);
      end
      idx_data = 5'(phase_idx[p]) | (5'($urandom_range(0, 3)) << 3);
      set_split(5'(phase_off[p]), idx_data);
      // One phase runs with both channels streaming flat out
      idle_en = (p != 2);
      for (int i = 0; i < phase_len[p]; i++) begin
        if (i == phase_len[p] / 2) wait_results_drained();
        op = ($urandom_range(0, 1) == 1) ? sacwt_pkg::OP_WRITE : sacwt_pkg::OP_READ;
        if ($urandom_range(0, 9) < 3) begin
          addr = $urandom();
        end else begin
          tag  = ($urandom_range(0, 4) == 4) ? 32'hFFFF_FFFF : 32'($urandom_range(0, 3));
          addr = compose_address(tag, 32'($urandom_range(0, 3)), $urandom());
        end
        send_access(op, addr);
      end
    end
    idle_en = 1'b1;
  endtask

  // Receiver: stall at random on the falling edge
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i = idle_en && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  task automatic check_field(string name, logic [ADDR_W-1:0] exp_v, logic [ADDR_W-1:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      if (errors <= 100) begin
        $display("%0t: %s mismatch: expected 0x%08h, actual 0x%08h", $time, name, exp_v, act_v);
      end
    end
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    access_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual hit=%0b fill=%0b wb=%0b va=0x%08h",
                 $time, hit_o, fill_needed_o, writeback_o, victim_address_o);
      end else begin
        exp_res = pending_results.pop_front();
        check_field("hit", 32'(exp_res.hit), 32'(hit_o));
        check_field("fill_needed", 32'(exp_res.fill_needed), 32'(fill_needed_o));
        check_field("writeback", 32'(exp_res.writeback), 32'(writeback_o));
        check_field("victim_address", exp_res.victim_address, victim_address_o);
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    opcode_i    = sacwt_pkg::OP_READ;
    address_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = sacwt_pkg::CFG_OFFSET_BITS;
    cfg_data_i  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_accesses();
    test_split_extremes();
    test_random_traffic();

    // Drain, then watch a little longer for stray results
    wait_results_drained();
    repeat (WAYS + 8) @(posedge clk_i);

    $display("Covered %0d accesses: %0d hits, %0d misses, %0d with writeback.",
             n_accesses, n_hits, n_misses, n_writebacks);
    $display("Used %0d split settings incl. clamped ones, random stalls on both channels.",
             n_settings);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
